// ===== design/address_range_region_table_assert.svh =====
// Assertion macros used by the region table RTL.
`ifndef ADDRESS_RANGE_REGION_TABLE_ASSERT_SVH
`define ADDRESS_RANGE_REGION_TABLE_ASSERT_SVH

// Same-cycle implication, clocked on clk, disabled in reset.
`define ARRT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arrt assertion failed");

// Next-cycle implication, clocked on clk, disabled in reset.
`define ARRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arrt assertion failed");

`endif

// ===== design/arrt_pkg.sv =====
`default_nettype none
package arrt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int PTR_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [1:0] ACT_INSERT  = 2'd0;
    localparam logic [1:0] ACT_FIND    = 2'd1;
    localparam logic [1:0] ACT_REMOVE  = 2'd2;
    localparam logic [1:0] ACT_RECYCLE = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_OVERLAP   = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [4:0] CNT_MAX = 5'd31;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] badge;
        logic [47:0] address;
        logic [47:0] region_length;
        logic [31:0] file_handle;
        logic [47:0] backing_offset;
        logic [31:0] map_flags;
        logic [3:0]  protection;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] area_offset;
        logic [31:0] found_handle;
        logic [47:0] found_offset;
        logic [31:0] found_flags;
        logic [3:0]  found_protection;
        logic [4:0]  removed_count;
    } rsp_t;

    typedef struct packed {
        logic [31:0] badge;
        logic [47:0] start;
        logic [47:0] length;
        logic [31:0] handle;
        logic [47:0] file_pos;
        logic [31:0] flags;
        logic [3:0]  protection;
    } entry_t;

    // Compare unit result for one entry against the held request
    typedef struct packed {
        logic        badge_hit;
        logic        overlap;
        logic        contains;
        logic        exact;
        logic [47:0] offset;
    } cmp_t;

endpackage
`default_nettype wire

// ===== design/arrt_if.sv =====
`default_nettype none
interface arrt_req_if;
    logic             valid;
    logic             ready;
    arrt_pkg::req_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface arrt_rsp_if;
    logic             valid;
    logic             ready;
    arrt_pkg::rsp_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/arrt_store.sv =====
`default_nettype none
// Entry memory: one write port, one registered read port.
module arrt_store (
    input  logic                       clk,
    input  logic                       we,
    input  logic [arrt_pkg::IDX_W-1:0] waddr,
    input  arrt_pkg::entry_t           wdata,
    input  logic [arrt_pkg::IDX_W-1:0] raddr,
    output arrt_pkg::entry_t           rdata
);

    arrt_pkg::entry_t mem [arrt_pkg::TABLE_ENTRIES];
    arrt_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== design/arrt_cmp.sv =====
`default_nettype none
// Shared compare unit: one entry against the held request.
// Region ends are 49 bits wide, so they never wrap.
module arrt_cmp (
    input  arrt_pkg::entry_t entry,
    input  arrt_pkg::req_t   req,
    output arrt_pkg::cmp_t   res
);

    logic [48:0] e_start;
    logic [48:0] e_end;
    logic [48:0] n_start;
    logic [48:0] n_end;

    always_comb
    begin
        e_start = {1'b0, entry.start};
        e_end   = {1'b0, entry.start} + {1'b0, entry.length};
        n_start = {1'b0, req.address};
        n_end   = {1'b0, req.address} + {1'b0, req.region_length};

        res.badge_hit = (entry.badge == req.badge);
        res.overlap   = (n_start < e_end) && (n_end > e_start);
        res.contains  = (e_start <= n_start) && (e_end > n_start);
        res.exact     = (entry.start == req.address) && (entry.length == req.region_length);
        res.offset    = req.address - entry.start;
    end

endmodule
`default_nettype wire

// ===== design/address_range_region_table.sv =====
// Items are handled one at a time: a request is taken only in the idle state, then the
//   scan and the result step run before the next transfer; the single read port of the
//   entry memory feeds one shared compare unit, one entry per cycle.
// A new item is taken while the previous result still waits in the output register.
// Reset (rst_n, async, active low) clears the valid bits and the sequencer;
//   entry memory contents are not cleared and need no clearing pass.
`default_nettype none
`include "address_range_region_table_assert.svh"
module address_range_region_table (
    input  logic       clk,
    input  logic       rst_n,
    arrt_req_if.sink   req,
    arrt_rsp_if.source rsp
);

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                              state_reg, state_next;
    arrt_pkg::req_t                      req_reg, req_next;
    logic [arrt_pkg::PTR_W-1:0]          rd_ptr_reg, rd_ptr_next;
    logic                                eval_vld_reg, eval_vld_next;
    logic [arrt_pkg::IDX_W-1:0]          eval_idx_reg, eval_idx_next;
    logic                                slot_found_reg, slot_found_next;
    logic [arrt_pkg::IDX_W-1:0]          slot_idx_reg, slot_idx_next;
    logic                                clash_reg, clash_next;
    logic                                hit_reg, hit_next;
    logic [arrt_pkg::IDX_W-1:0]          hit_idx_reg, hit_idx_next;
    logic [4:0]                          cnt_reg, cnt_next;
    arrt_pkg::rsp_t                      res_reg, res_next;
    logic                                out_valid_reg, out_valid_next;
    arrt_pkg::rsp_t                      out_reg, out_next;
    logic [arrt_pkg::TABLE_ENTRIES-1:0]  valid_reg, valid_next;

    logic                                issue;
    logic                                out_free;
    logic                                cur_valid;
    logic                                mem_we;
    arrt_pkg::entry_t                    mem_wdata;
    arrt_pkg::entry_t                    rdata;
    arrt_pkg::cmp_t                      cmp;

    // Entry memory, read address walks 0..TABLE_ENTRIES-1 during the scan
    arrt_store u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (slot_idx_reg),
        .wdata (mem_wdata),
        .raddr (rd_ptr_reg[arrt_pkg::IDX_W-1:0]),
        .rdata (rdata)
    );

    // One compare unit, reused for every entry
    arrt_cmp u_cmp (
        .entry (rdata),
        .req   (req_reg),
        .res   (cmp)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    assign issue     = (state_reg == ST_SCAN) &&
                       (rd_ptr_reg != arrt_pkg::PTR_W'(arrt_pkg::TABLE_ENTRIES));
    assign out_free  = !out_valid_reg || rsp.ready;
    assign cur_valid = valid_reg[eval_idx_reg];

    always_comb
    begin
        mem_wdata.badge      = req_reg.badge;
        mem_wdata.start      = req_reg.address;
        mem_wdata.length     = req_reg.region_length;
        mem_wdata.handle     = req_reg.file_handle;
        mem_wdata.file_pos   = req_reg.backing_offset;
        mem_wdata.flags      = req_reg.map_flags;
        mem_wdata.protection = req_reg.protection;
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        rd_ptr_next     = rd_ptr_reg;
        eval_vld_next   = 1'b0;
        eval_idx_next   = eval_idx_reg;
        slot_found_next = slot_found_reg;
        slot_idx_next   = slot_idx_reg;
        clash_next      = clash_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        cnt_next        = cnt_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        valid_next      = valid_reg;
        mem_we          = 1'b0;

        // result taken downstream
        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    req_next        = req.data;
                    rd_ptr_next     = '0;
                    slot_found_next = 1'b0;
                    clash_next      = 1'b0;
                    hit_next        = 1'b0;
                    cnt_next        = '0;
                    res_next        = '0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // read stage
                eval_vld_next = issue;
                eval_idx_next = rd_ptr_reg[arrt_pkg::IDX_W-1:0];
                if (issue)
                begin
                    rd_ptr_next = rd_ptr_reg + arrt_pkg::PTR_W'(1);
                end

                // evaluate stage, entry read in the previous cycle
                if (eval_vld_reg)
                begin
                    case (req_reg.action)
                        arrt_pkg::ACT_INSERT:
                        begin
                            if (!cur_valid && !slot_found_reg)
                            begin
                                slot_found_next = 1'b1;
                                slot_idx_next   = eval_idx_reg;
                            end
                            if (cur_valid && cmp.badge_hit && cmp.overlap)
                            begin
                                clash_next = 1'b1;
                            end
                        end
                        arrt_pkg::ACT_FIND:
                        begin
                            if (cur_valid && cmp.badge_hit && cmp.contains && !hit_reg)
                            begin
                                hit_next                  = 1'b1;
                                res_next.area_offset      = cmp.offset;
                                res_next.found_handle     = rdata.handle;
                                res_next.found_offset     = rdata.file_pos;
                                res_next.found_flags      = rdata.flags;
                                res_next.found_protection = rdata.protection;
                            end
                        end
                        arrt_pkg::ACT_REMOVE:
                        begin
                            if (cur_valid && cmp.badge_hit && cmp.exact && !hit_reg)
                            begin
                                hit_next     = 1'b1;
                                hit_idx_next = eval_idx_reg;
                            end
                        end
                        arrt_pkg::ACT_RECYCLE:
                        begin
                            if (cur_valid && cmp.badge_hit)
                            begin
                                valid_next[eval_idx_reg] = 1'b0;
                                if (cnt_reg != arrt_pkg::CNT_MAX)
                                begin
                                    cnt_next = cnt_reg + 5'd1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end

                if (!issue)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                // commit and post the result once the output register is free
                if (out_free)
                begin
                    out_next       = '0;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    case (req_reg.action)
                        arrt_pkg::ACT_INSERT:
                        begin
                            if (!slot_found_reg)
                            begin
                                out_next.status = arrt_pkg::ST_FULL;
                            end
                            else if (clash_reg)
                            begin
                                out_next.status = arrt_pkg::ST_OVERLAP;
                            end
                            else
                            begin
                                out_next.status          = arrt_pkg::ST_OK;
                                mem_we                   = 1'b1;
                                valid_next[slot_idx_reg] = 1'b1;
                            end
                        end
                        arrt_pkg::ACT_FIND:
                        begin
                            if (hit_reg)
                            begin
                                out_next        = res_reg;
                                out_next.status = arrt_pkg::ST_OK;
                            end
                            else
                            begin
                                out_next.status = arrt_pkg::ST_NOT_FOUND;
                            end
                        end
                        arrt_pkg::ACT_REMOVE:
                        begin
                            if (hit_reg)
                            begin
                                out_next.status         = arrt_pkg::ST_OK;
                                out_next.removed_count  = 5'd1;
                                valid_next[hit_idx_reg] = 1'b0;
                            end
                            else
                            begin
                                out_next.status = arrt_pkg::ST_NOT_FOUND;
                            end
                        end
                        arrt_pkg::ACT_RECYCLE:
                        begin
                            out_next.status        = arrt_pkg::ST_OK;
                            out_next.removed_count = cnt_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rd_ptr_reg     <= '0;
            eval_vld_reg   <= 1'b0;
            slot_found_reg <= 1'b0;
            clash_reg      <= 1'b0;
            hit_reg        <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            valid_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_ptr_reg     <= rd_ptr_next;
            eval_vld_reg   <= eval_vld_next;
            slot_found_reg <= slot_found_next;
            clash_reg      <= clash_next;
            hit_reg        <= hit_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            valid_reg      <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        eval_idx_reg <= eval_idx_next;
        slot_idx_reg <= slot_idx_next;
        hit_idx_reg  <= hit_idx_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    `ARRT_ASSERT_NEXT(a_accept_starts_scan, req.valid && req.ready, state_reg == ST_SCAN && rd_ptr_reg == '0 && !eval_vld_reg)
    `ARRT_ASSERT_NOW(a_eval_in_scan, eval_vld_reg, state_reg == ST_SCAN)
    `ARRT_ASSERT_NOW(a_insert_free_slot, mem_we, !valid_reg[slot_idx_reg] && req_reg.action == arrt_pkg::ACT_INSERT)
    `ARRT_ASSERT_NEXT(a_finish_waits, state_reg == ST_FINISH && out_valid_reg && !rsp.ready, state_reg == ST_FINISH)
    `ARRT_ASSERT_NEXT(a_fill_by_one, 1'b1, $countones(valid_reg) <= $countones($past(valid_reg)) + 1)

endmodule
`default_nettype wire

// ===== dv/region_table_checker.sv =====
`default_nettype none
module region_table_checker
    import arrt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req_data,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp_data,
    output int   fail_count,
    output int   pending_count
);

    // Shadow copy of the region table
    logic   shadow_valid [TABLE_ENTRIES];
    entry_t shadow_entry [TABLE_ENTRIES];

    rsp_t expected_rsp_q [$];
    rsp_t want;
    int   result_index;

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
        result_index  = 0;
    end

    task automatic report(input string msg);
        fail_count++;
        $display("[%0t] result %0d: %s", $realtime, result_index, msg);
    endtask

    // Apply one action to the shadow table and return its answer.
    // Region ends are 49 bits wide, so they never wrap.
    function automatic rsp_t apply_action(input req_t r);
        rsp_t        res;
        entry_t      e;
        logic [48:0] new_end;
        logic [48:0] old_end;
        int          slot;
        bit          clash;
        bit          done;
        res     = '0;
        slot    = -1;
        clash   = 0;
        done    = 0;
        new_end = {1'b0, r.address} + {1'b0, r.region_length};
        case (r.action)
            ACT_INSERT:
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (!shadow_valid[i])
                    begin
                        if (slot < 0)
                            slot = i;
                    end
                    else if (shadow_entry[i].badge == r.badge)
                    begin
                        old_end = {1'b0, shadow_entry[i].start} + {1'b0, shadow_entry[i].length};
                        if ({1'b0, r.address} < old_end && new_end > {1'b0, shadow_entry[i].start})
                            clash = 1;
                    end
                end
                if (slot < 0)
                    res.status = ST_FULL;
                else if (clash)
                    res.status = ST_OVERLAP;
                else
                begin
                    e.badge      = r.badge;
                    e.start      = r.address;
                    e.length     = r.region_length;
                    e.handle     = r.file_handle;
                    e.file_pos   = r.backing_offset;
                    e.flags      = r.map_flags;
                    e.protection = r.protection;
                    shadow_entry[slot] = e;
                    shadow_valid[slot] = 1'b1;
                    res.status         = ST_OK;
                end
            end
            ACT_FIND:
            begin
                res.status = ST_NOT_FOUND;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    old_end = {1'b0, shadow_entry[i].start} + {1'b0, shadow_entry[i].length};
                    if (!done && shadow_valid[i] && shadow_entry[i].badge == r.badge &&
                        shadow_entry[i].start <= r.address && old_end > {1'b0, r.address})
                    begin
                        done                 = 1;
                        res.status           = ST_OK;
                        res.area_offset      = r.address - shadow_entry[i].start;
                        res.found_handle     = shadow_entry[i].handle;
                        res.found_offset     = shadow_entry[i].file_pos;
                        res.found_flags      = shadow_entry[i].flags;
                        res.found_protection = shadow_entry[i].protection;
                    end
                end
            end
            ACT_REMOVE:
            begin
                res.status = ST_NOT_FOUND;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (!done && shadow_valid[i] && shadow_entry[i].badge == r.badge &&
                        shadow_entry[i].start == r.address &&
                        shadow_entry[i].length == r.region_length)
                    begin
                        done              = 1;
                        shadow_valid[i]   = 1'b0;
                        res.status        = ST_OK;
                        res.removed_count = 5'd1;
                    end
                end
            end
            default:
            begin
                res.status = ST_OK;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (shadow_valid[i] && shadow_entry[i].badge == r.badge)
                    begin
                        shadow_valid[i] = 1'b0;
                        if (res.removed_count < CNT_MAX)
                            res.removed_count++;
                    end
                end
            end
        endcase
        return res;
    endfunction

    task automatic compare_result(input rsp_t got, input rsp_t exp_rsp);
        if (got.status !== exp_rsp.status)
            report($sformatf("status got %0h want %0h", got.status, exp_rsp.status));
        if (got.area_offset !== exp_rsp.area_offset)
            report($sformatf("area_offset got %0h want %0h",
                             got.area_offset, exp_rsp.area_offset));
        if (got.found_handle !== exp_rsp.found_handle)
            report($sformatf("found_handle got %0h want %0h",
                             got.found_handle, exp_rsp.found_handle));
        if (got.found_offset !== exp_rsp.found_offset)
            report($sformatf("found_offset got %0h want %0h",
                             got.found_offset, exp_rsp.found_offset));
        if (got.found_flags !== exp_rsp.found_flags)
            report($sformatf("found_flags got %0h want %0h",
                             got.found_flags, exp_rsp.found_flags));
        if (got.found_protection !== exp_rsp.found_protection)
            report($sformatf("found_protection got %0h want %0h",
                             got.found_protection, exp_rsp.found_protection));
        if (got.removed_count !== exp_rsp.removed_count)
            report($sformatf("removed_count got %0d want %0d",
                             got.removed_count, exp_rsp.removed_count));
    endtask

    // Result side goes first so a request taken on the same edge
    // cannot be matched against its own answer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                shadow_valid[i] = 1'b0;
            expected_rsp_q.delete();
            pending_count = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp_q.size() == 0)
                    report("result with no request pending");
                else
                begin
                    want = expected_rsp_q.pop_front();
                    compare_result(rsp_data, want);
                end
                result_index++;
            end
            if (req_valid && req_ready)
                expected_rsp_q.push_back(apply_action(req_data));
            pending_count = expected_rsp_q.size();
        end
    end

endmodule
`default_nettype wire

// ===== dv/address_range_region_table_tb.sv =====
`default_nettype none
module address_range_region_table_tb;
    import arrt_pkg::*;

    // One action walks the whole table, plus setup and result cycles.
    localparam int LATENCY     = TABLE_ENTRIES + 2;
    localparam int RANDOM_ITEMS = 750;
    // ~780 transfers; worst case per transfer is the scan, the longest sender
    // gap and the longest receiver stall together. Taken ~5x over.
    localparam int CYCLE_LIMIT = 500000;

    // Region sent with an insert, kept so later finds and removes can aim at it
    typedef struct packed {
        logic [31:0] badge;
        logic [47:0] start;
        logic [47:0] length;
    } placed_t;

    logic clk;
    logic rst_n;

    arrt_req_if req_ch ();
    arrt_rsp_if rsp_ch ();

    int chk_fails;
    int chk_pending;

    placed_t recent_regions [$];
    int      sent_per_action [4];
    int      burst_left;
    int      cycle_count;

    address_range_region_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    region_table_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_ch.valid),
        .req_ready     (req_ch.ready),
        .req_data      (req_ch.data),
        .rsp_valid     (rsp_ch.valid),
        .rsp_ready     (rsp_ch.ready),
        .rsp_data      (rsp_ch.data),
        .fail_count    (chk_fails),
        .pending_count (chk_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Random value helpers
    // ------------------------------------------------------------------
    function automatic logic [47:0] rand48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[47:0];
    endfunction

    // Mostly a few shared badges so overlaps and recycles bite; sometimes
    // a full random badge so every bit toggles.
    function automatic logic [31:0] pick_badge();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1:    return 32'h0000_0000;
            2, 3:    return 32'h0000_0001;
            4, 5:    return 32'hFFFF_FFFF;
            6, 7:    return 32'h8000_0001;
            default: return $urandom;
        endcase
    endfunction

    // Stored payload is random for every action; only insert keeps it.
    function automatic req_t make_req(input logic [1:0]  act,
                                      input logic [31:0] badge,
                                      input logic [47:0] addr,
                                      input logic [47:0] len);
        req_t r;
        r.action         = act;
        r.badge          = badge;
        r.address        = addr;
        r.region_length  = len;
        r.file_handle    = $urandom;
        r.backing_offset = rand48();
        r.map_flags      = $urandom;
        r.protection     = 4'($urandom_range(0, 15));
        return r;
    endfunction

    function automatic req_t random_insert();
        logic [47:0] start;
        logic [47:0] len;
        int          m;
        m = $urandom_range(0, 99);
        if (m < 70)
        begin
            // dense 64 KB window: lots of overlaps and neighbors
            start = 48'($urandom_range(0, 255)) << 8;
            case ($urandom_range(0, 3))
                0:       len = '0;
                1:       len = 48'd1;
                2:       len = 48'($urandom_range(1, 'h400));
                default: len = 48'($urandom_range(1, 4)) << 8;
            endcase
        end
        else if (m < 85)
        begin
            // top of the address space, ends run past 48 bits
            start = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 'hFFF));
            len   = $urandom_range(0, 1) ? rand48() : 48'($urandom_range(0, 'h2000));
        end
        else
        begin
            start = rand48();
            len   = rand48();
        end
        return make_req(ACT_INSERT, pick_badge(), start, len);
    endfunction

    function automatic req_t random_find();
        placed_t     p;
        logic [31:0] badge;
        logic [47:0] addr;
        logic [63:0] inner;
        if (recent_regions.size() > 0 && $urandom_range(0, 9) < 8)
        begin
            p     = recent_regions[$urandom_range(0, recent_regions.size() - 1)];
            badge = ($urandom_range(0, 9) == 0) ? pick_badge() : p.badge;
            inner = (p.length == '0) ? 64'd0 : {$urandom, $urandom} % {16'h0, p.length};
            case ($urandom_range(0, 4))
                0:       addr = p.start;
                1:       addr = p.start + p.length - 48'd1;
                2:       addr = p.start + p.length;      // first byte past the end
                3:       addr = p.start + inner[47:0];
                default: addr = p.start - 48'd1;
            endcase
        end
        else
        begin
            badge = pick_badge();
            addr  = $urandom_range(0, 1) ? rand48() : 48'($urandom_range(0, 'hFFFF));
        end
        return make_req(ACT_FIND, badge, addr, rand48());
    endfunction

    function automatic req_t random_remove();
        placed_t p;
        int      m;
        m = $urandom_range(0, 99);
        if (recent_regions.size() > 0 && m < 85)
        begin
            p = recent_regions[$urandom_range(0, recent_regions.size() - 1)];
            if (m < 75)
                return make_req(ACT_REMOVE, p.badge, p.start, p.length);
            // near miss: length off by one
            return make_req(ACT_REMOVE, p.badge, p.start, p.length + 48'd1);
        end
        return make_req(ACT_REMOVE, pick_badge(), rand48(), rand48());
    endfunction

    // ------------------------------------------------------------------
    // Request side: bursts of transfers with random gaps
    // ------------------------------------------------------------------
    task automatic send_item(input req_t item);
        req_ch.data  = item;
        req_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            // a third of the bursts follow on with no gap at all
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                req_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    task automatic issue(input req_t item);
        placed_t p;
        send_item(item);
        sent_per_action[item.action]++;
        if (item.action == ACT_INSERT)
        begin
            p.badge  = item.badge;
            p.start  = item.address;
            p.length = item.region_length;
            recent_regions.push_back(p);
            if (recent_regions.size() > 32)
                void'(recent_regions.pop_front());
        end
        pace();
    endtask

    // ------------------------------------------------------------------
    // Result side: stalls in phases of its own
    // ------------------------------------------------------------------
    initial
    begin
        int mode;
        int span;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = (mode == 2) ? $urandom_range(5, 60) : $urandom_range(20, 200);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0:       rsp_ch.ready = 1'b1;               // no stalls
                    1:       rsp_ch.ready = 1'($urandom_range(0, 1));
                    2:       rsp_ch.ready = 1'b0;               // one long stall
                    default: rsp_ch.ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------
    initial
    begin
        int w;
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        burst_left   = 0;
        for (int a = 0; a < 4; a++)
            sent_per_action[a] = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // --- directed ---
        issue(make_req(ACT_FIND,   32'd0, 48'h0,    48'h0));      // empty table
        issue(make_req(ACT_INSERT, 32'd0, 48'h0,    48'h1000));
        issue(make_req(ACT_INSERT, 32'd0, 48'h800,  48'h1000));   // overlap, same badge
        issue(make_req(ACT_INSERT, 32'd1, 48'h800,  48'h1000));   // other badge is fine
        issue(make_req(ACT_INSERT, 32'd0, 48'h1000, 48'h10));     // touches the end only
        issue(make_req(ACT_INSERT, 32'd0, 48'h500,  48'h0));      // empty region inside: overlap
        issue(make_req(ACT_INSERT, 32'd0, 48'h1010, 48'h0));      // empty region on an edge
        issue(make_req(ACT_FIND,   32'd0, 48'hFFF,  48'h0));      // last byte of a region
        issue(make_req(ACT_FIND,   32'd0, 48'h1010, 48'h0));      // empty region never hit
        issue(make_req(ACT_INSERT, '1,    '1,       '1));         // end beyond 48 bits
        issue(make_req(ACT_FIND,   '1,    '1,       48'h0));
        issue(make_req(ACT_REMOVE, 32'd0, 48'h0,    48'h1000));   // exact hit
        issue(make_req(ACT_REMOVE, 32'd0, 48'h0,    48'h1000));   // now gone
        // four regions stay live; fill the rest with badge 2
        for (int k = 0; k < TABLE_ENTRIES - 4; k++)
            issue(make_req(ACT_INSERT, 32'd2, 48'(k) << 16, 48'h100));
        // full wins over overlap
        issue(make_req(ACT_INSERT, 32'd2, 48'h0, 48'h100));
        issue(make_req(ACT_RECYCLE, 32'd2, rand48(), rand48()));

        // --- random ---
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            w = $urandom_range(0, 99);
            if (w < 40)
                issue(random_insert());
            else if (w < 70)
                issue(random_find());
            else if (w < 88)
                issue(random_remove());
            else
                issue(make_req(ACT_RECYCLE, pick_badge(), rand48(), rand48()));
        end
        req_ch.valid = 1'b0;

        // drain, then give a stray late result time to show up
        while (chk_pending != 0)
            @(negedge clk);
        repeat (3 * LATENCY) @(negedge clk);

        $display("covered %0d transfers: %0d insert, %0d find, %0d remove, %0d recycle",
                 sent_per_action[0] + sent_per_action[1] + sent_per_action[2] +
                 sent_per_action[3], sent_per_action[ACT_INSERT], sent_per_action[ACT_FIND],
                 sent_per_action[ACT_REMOVE], sent_per_action[ACT_RECYCLE]);
        $display("field mismatches: %0d", chk_fails);
        if (chk_fails == 0)
            $display("address_range_region_table: match");
        else
            $display("address_range_region_table: mismatch");
        $finish;
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("address_range_region_table: mismatch");
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/arrt_pkg.sv
design/arrt_if.sv
design/arrt_store.sv
design/arrt_cmp.sv
design/address_range_region_table.sv
dv/region_table_checker.sv
dv/address_range_region_table_tb.sv
